FILE: rtl/tnp_pkg.sv
// shared constants, run descriptor type and terminal-type answer table for the telnet parser
package tnp_pkg;

	localparam logic [7:0] TN_IAC  = 8'd255;
	localparam logic [7:0] TN_DONT = 8'd254;
	localparam logic [7:0] TN_DO   = 8'd253;
	localparam logic [7:0] TN_WONT = 8'd252;
	localparam logic [7:0] TN_WILL = 8'd251;
	localparam logic [7:0] TN_SB   = 8'd250;
	localparam logic [7:0] TN_SE   = 8'd240;
	localparam logic [7:0] TN_EOR  = 8'd239;

	localparam logic [7:0] OPT_ECHO  = 8'd1;
	localparam logic [7:0] OPT_TTYPE = 8'd24;
	localparam logic [7:0] OPT_EOR   = 8'd25;

	localparam logic [7:0] QUAL_IS   = 8'd0;
	localparam logic [7:0] QUAL_SEND = 8'd1;

	// index into a reply run; the longest run has eleven bytes
	localparam int IDX_W = 4;
	localparam logic [IDX_W-1:0] REPLY_LAST = 4'd2;
	localparam logic [IDX_W-1:0] TTYPE_LAST = 4'd10;

	typedef enum logic [1:0] {
		RK_NONE,
		RK_DATA,
		RK_REPLY,
		RK_TTYPE
	} run_kind_t;

	// what one received byte produces: nothing, a data byte, a three-byte reply or the ttype answer
	typedef struct packed {
		run_kind_t  kind;
		logic [7:0] cmd;
		logic [7:0] val;
		logic       echo;
	} run_t;

	// IAC SB TTYPE IS "VT100" IAC SE
	function automatic logic [7:0] ttype_byte(input logic [IDX_W-1:0] idx);
		logic [7:0] b;
		unique case (idx)
			4'd0:    b = TN_IAC;
			4'd1:    b = TN_SB;
			4'd2:    b = OPT_TTYPE;
			4'd3:    b = QUAL_IS;
			4'd4:    b = 8'd86;
			4'd5:    b = 8'd84;
			4'd6:    b = 8'd49;
			4'd7:    b = 8'd48;
			4'd8:    b = 8'd48;
			4'd9:    b = TN_IAC;
			4'd10:   b = TN_SE;
			default: b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

FILE: rtl/tnp_parse.sv
// telnet command parser: parse state, option and subnegotiation registers, run decode
module tnp_parse
	import tnp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] rx_byte,
	output run_t       run
);

	typedef enum logic [3:0] {
		S_DATA,
		S_IAC,
		S_SB,
		S_WILL,
		S_DO,
		S_WONT,
		S_DONT,
		S_SBIAC,
		S_SBDATA,
		S_SBDATAIAC
	} pstate_t;

	pstate_t    state_q, state_d;
	logic [7:0] option_q, option_d;
	logic [7:0] sb_first_q, sb_first_d;
	logic       sb_has_q, sb_has_d;
	logic       echo_q, echo_d;
	logic       sb_send;

	assign sb_send = (option_q == OPT_TTYPE) && sb_has_q && (sb_first_q == QUAL_SEND);

	always_comb begin
		state_d    = state_q;
		option_d   = option_q;
		sb_first_d = sb_first_q;
		sb_has_d   = sb_has_q;
		echo_d     = echo_q;
		run.kind   = RK_NONE;
		run.cmd    = TN_DONT;
		run.val    = rx_byte;
		unique case (state_q)
			S_DATA: begin
				if (rx_byte == TN_IAC) state_d = S_IAC;
				else run.kind = RK_DATA;
			end
			S_IAC: begin
				state_d = S_DATA;
				priority if (rx_byte == TN_IAC) run.kind = RK_DATA;
				else if (rx_byte == TN_WILL) state_d = S_WILL;
				else if (rx_byte == TN_WONT) state_d = S_WONT;
				else if (rx_byte == TN_DO) state_d = S_DO;
				else if (rx_byte == TN_DONT) state_d = S_DONT;
				else if (rx_byte == TN_SB) begin
					state_d  = S_SB;
					sb_has_d = 1'b0;
				end
				else state_d = S_DATA;
			end
			S_WILL: begin
				run.kind = RK_REPLY;
				if (rx_byte == OPT_ECHO) echo_d = 1'b1;
				run.cmd = (rx_byte == OPT_ECHO || rx_byte == OPT_EOR) ? TN_DO : TN_DONT;
				state_d = S_DATA;
			end
			S_WONT: begin
				run.kind = RK_REPLY;
				if (rx_byte == OPT_ECHO) echo_d = 1'b0;
				run.cmd = TN_DONT;
				state_d = S_DATA;
			end
			S_DO: begin
				run.kind = RK_REPLY;
				run.cmd  = (rx_byte == OPT_ECHO || rx_byte == OPT_TTYPE) ? TN_WILL : TN_WONT;
				state_d  = S_DATA;
			end
			S_DONT: begin
				run.kind = RK_REPLY;
				run.cmd  = TN_WONT;
				state_d  = S_DATA;
			end
			S_SB: begin
				if (rx_byte == TN_IAC) state_d = S_SBIAC;
				else begin
					option_d   = rx_byte;
					sb_has_d   = 1'b0;
					sb_first_d = 8'd0;
					state_d    = S_SBDATA;
				end
			end
			S_SBIAC: begin
				if (rx_byte == TN_IAC) begin
					option_d   = rx_byte;
					sb_has_d   = 1'b0;
					sb_first_d = 8'd0;
					state_d    = S_SBDATA;
				end
				else state_d = S_DATA;
			end
			S_SBDATA: begin
				if (rx_byte == TN_IAC) state_d = S_SBDATAIAC;
				else if (!sb_has_q) begin
					sb_first_d = rx_byte;
					sb_has_d   = 1'b1;
				end
			end
			S_SBDATAIAC: begin
				priority if (rx_byte == TN_IAC) begin
					if (!sb_has_q) begin
						sb_first_d = rx_byte;
						sb_has_d   = 1'b1;
					end
					state_d = S_SBDATA;
				end
				else if (rx_byte == TN_SE) begin
					if (sb_send) run.kind = RK_TTYPE;
					option_d = 8'd0;
					state_d  = S_DATA;
				end
				else if (rx_byte == TN_SB) begin
					if (sb_send) run.kind = RK_TTYPE;
					state_d = S_SB;
				end
				else state_d = S_DATA;
			end
			default: state_d = S_DATA;
		endcase
		run.echo = echo_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_DATA;
			option_q   <= 8'd0;
			sb_first_q <= 8'd0;
			sb_has_q   <= 1'b0;
			echo_q     <= 1'b0;
		end else if (take) begin
			state_q    <= state_d;
			option_q   <= option_d;
			sb_first_q <= sb_first_d;
			sb_has_q   <= sb_has_d;
			echo_q     <= echo_d;
		end
	end

endmodule

FILE: rtl/tnp_emit.sv
// result sequencer: holds one run and plays out its bytes one transfer at a time
module tnp_emit
	import tnp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  run_t       run,
	output logic       free,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       out_dest,
	output logic [7:0] out_byte,
	output logic       last_of_run,
	output logic       echo_flag
);

	logic             valid_q;
	run_t             run_q;
	logic [IDX_W-1:0] idx_q;

	always_comb begin
		unique case (run_q.kind)
			RK_DATA: begin
				last_of_run = 1'b1;
				out_byte    = run_q.val;
			end
			RK_REPLY: begin
				last_of_run = (idx_q == REPLY_LAST);
				unique case (idx_q)
					4'd0:    out_byte = TN_IAC;
					4'd1:    out_byte = run_q.cmd;
					default: out_byte = run_q.val;
				endcase
			end
			RK_TTYPE: begin
				last_of_run = (idx_q == TTYPE_LAST);
				out_byte    = ttype_byte(idx_q);
			end
			default: begin
				last_of_run = 1'b1;
				out_byte    = run_q.val;
			end
		endcase
	end

	assign out_valid = valid_q;
	assign out_dest  = (run_q.kind != RK_DATA);
	assign echo_flag = run_q.echo;
	assign free      = !valid_q || (out_ready && last_of_run);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (valid_q && out_ready) begin
			if (last_of_run) valid_q <= 1'b0;
			else idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) run_q <= run;
	end

endmodule

FILE: rtl/telnet_iac_negotiation_parser.sv
// top level of the telnet receive parser and option negotiation responder
//
// One received byte is taken per transfer on the rx side and decoded in the
// same cycle into a run of zero, one, three or eleven result bytes, which a
// run register then plays out one transfer per cycle while out_ready is high;
// data bytes then flow at one byte per cycle with no bubbles. A three-byte
// negotiation reply or the eleven-byte terminal-type answer holds the input
// until its last byte transfers; the limit is the single run register, which
// takes the next byte's run in the same cycle its last byte transfers. Bytes
// that produce nothing (command prefixes, subnegotiation payload) are taken
// whenever the run register can accept a run. echo_flag gives the remote echo
// state after the byte that caused the run; last_of_run marks its final byte.
module telnet_iac_negotiation_parser
	import tnp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       out_dest,
	output logic [7:0] out_byte,
	output logic       last_of_run,
	output logic       echo_flag
);

	run_t run;
	logic take;
	logic free;

	// a received byte is consumed only when the run register can take its result
	assign in_ready = free;
	assign take     = in_valid && in_ready;

	tnp_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.rx_byte (rx_byte),
		.run     (run)
	);

	// silent bytes only advance parser state and never load the run register
	tnp_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (take && (run.kind != RK_NONE)),
		.run         (run),
		.free        (free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_dest    (out_dest),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.echo_flag   (echo_flag)
	);

	// input is open only when the current run is absent or finishing
	a_ready_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready && out_valid |-> last_of_run)
		else $error("input taken while a run is mid-flight");

	// a run keeps going until its last byte transfers
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid && !out_dest == 1'b0)
		else $error("run ended before its last byte");

	// application data is always a single-byte run
	a_data_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_dest |-> last_of_run)
		else $error("data byte not marked last");

	// echo state is fixed across all bytes of one run
	a_echo_per_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> $stable(echo_flag))
		else $error("echo flag changed within a run");

endmodule
